// ----- rtl/core/iba_pkg.sv -----
// shared types and codes for the indexed block allocator
// item and result payloads, status codes, controller/datapath command and status bundles
// no dependencies
package iba_pkg;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_ALLOC      = 3'd1,
    ST_INDEX_BUSY = 3'd2,
    ST_BLOCK_BUSY = 3'd3,
    ST_DELETED    = 3'd4,
    ST_NOT_FOUND  = 3'd5,
    ST_FULL       = 3'd6,
    ST_RANGE      = 3'd7
  } status_t;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] index_block;
    logic [7:0] data_block;
    logic       last;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] blocks_changed;
  } out_t;

  typedef enum logic [1:0] {
    CHG_ZERO = 2'd0,
    CHG_DEL  = 2'd1,
    CHG_CNT  = 2'd2
  } chg_sel_t;

  typedef struct packed {
    logic     load;
    logic     clr_walk;
    logic     del_step;
    logic     list_step;
    logic     com_step;
    logic     fin_del;
    logic     fin_com;
    logic     close;
    logic     emit;
    status_t  code;
    chg_sel_t chg_sel;
  } cmd_t;

  typedef struct packed {
    logic    in_oor;
    logic    idx_oor;
    logic    idx_busy;
    logic    blk_conf;
    logic    list_hit;
    logic    list_last;
    logic    room_short;
    logic    slot_free;
    logic    slot_last;
    logic    del_found;
    status_t err;
  } sts_t;

endpackage

// ----- rtl/core/iba_ctrl.sv -----
// sequencing state machine for the indexed block allocator
// drives cmd_t to iba_datapath and reads back sts_t; uses iba_pkg
module iba_ctrl
  import iba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  logic last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DEL    = 5'b00010,
    S_CHK    = 5'b00100,
    S_LIST   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_PENDING;
    cmd.chg_sel = CHG_ZERO;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.clr_walk = 1'b1;
          if (kind == KIND_DELETE) begin
            if (sts.in_oor) begin
              cmd.emit = 1'b1;
              cmd.code = ST_RANGE;
            end else begin
              state_next = S_DEL;
            end
          end else if (!last) begin
            cmd.emit = 1'b1;
            cmd.code = ST_PENDING;
          end else begin
            state_next = S_CHK;
          end
        end
      end
      S_DEL: begin
        cmd.del_step = 1'b1;
        if (sts.slot_last) begin
          cmd.emit    = 1'b1;
          cmd.chg_sel = CHG_DEL;
          if (sts.del_found) begin
            cmd.fin_del = 1'b1;
            cmd.code    = ST_DELETED;
          end else begin
            cmd.code = ST_NOT_FOUND;
          end
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.err != ST_PENDING) begin
          cmd.emit  = 1'b1;
          cmd.code  = sts.err;
          cmd.close = 1'b1;
          state_next = S_IDLE;
        end else if (sts.idx_oor) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_RANGE;
          cmd.close = 1'b1;
          state_next = S_IDLE;
        end else if (sts.idx_busy) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_INDEX_BUSY;
          cmd.close = 1'b1;
          state_next = S_IDLE;
        end else if (sts.blk_conf) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_BLOCK_BUSY;
          cmd.close = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (sts.list_hit) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_BLOCK_BUSY;
          cmd.close = 1'b1;
          state_next = S_IDLE;
        end else if (sts.list_last) begin
          if (sts.room_short) begin
            cmd.emit  = 1'b1;
            cmd.code  = ST_FULL;
            cmd.close = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.clr_walk = 1'b1;
            state_next   = S_COMMIT;
          end
        end else begin
          cmd.list_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.com_step = 1'b1;
        if (sts.slot_free && sts.list_last) begin
          cmd.fin_com = 1'b1;
          cmd.emit    = 1'b1;
          cmd.code    = ST_ALLOC;
          cmd.chg_sel = CHG_CNT;
          cmd.close   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/iba_datapath.sv -----
// storage and walk logic for the indexed block allocator
// free bitmap, directory memory, pending list memory, result register; uses iba_pkg
module iba_datapath
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64,
  parameter int DIR_DEPTH  = 64,
  parameter int MAX_LIST   = 16
) (
  input  logic clk,
  input  logic rst,
  input  in_t  item,
  input  cmd_t cmd,
  output sts_t sts,
  output logic done,
  output out_t result
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int DW = $clog2(DIR_DEPTH);
  localparam int FW = $clog2(DIR_DEPTH + 1);
  localparam int LW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int CW = $clog2(MAX_LIST + 1);
  localparam int RW = (FW > CW) ? FW : CW;

  localparam logic [8:0]    NB_LIMIT  = 9'(NUM_BLOCKS);
  localparam logic [DW-1:0] SLOT_LAST = DW'(DIR_DEPTH - 1);
  localparam logic [CW-1:0] LIST_MAX  = CW'(MAX_LIST);
  localparam logic [FW-1:0] DIR_SIZE  = FW'(DIR_DEPTH);

  typedef struct packed {
    logic [BW-1:0] key;
    logic [BW-1:0] blk;
  } dir_ent_t;

  // directory and pending list storage
  dir_ent_t      dir_mem [DIR_DEPTH];
  dir_ent_t      dir_q;
  logic [BW-1:0] pend_mem [MAX_LIST];
  logic [BW-1:0] pend_q;

  logic [NUM_BLOCKS-1:0] free_map, free_map_next;
  logic [NUM_BLOCKS-1:0] req_map;
  logic [DIR_DEPTH-1:0]  dir_valid, dir_valid_next;
  logic [FW-1:0]         dir_fill;
  logic [CW-1:0]         pend_cnt;
  status_t               pend_err;
  logic                  dup;
  logic [7:0]            idx_q;

  logic [DW-1:0] slot, slot_next;
  logic [CW-1:0] lptr, lptr_next;
  logic [FW-1:0] del_n, del_n_final;

  logic [BW-1:0] idx_blk;
  logic [BW-1:0] in_blk;
  logic          blk_oor;
  logic          list_full;
  logic          append;
  logic          del_hit;
  logic          slot_free;
  logic [FW-1:0] room;

  assign idx_blk   = idx_q[BW-1:0];
  assign in_blk    = item.data_block[BW-1:0];
  assign blk_oor   = ({1'b0, item.data_block} >= NB_LIMIT);
  assign list_full = (pend_cnt >= LIST_MAX);
  assign append    = cmd.load && (item.kind == KIND_CREATE) && !blk_oor && !list_full;
  assign slot_free = !dir_valid[slot];
  assign del_hit   = dir_valid[slot] && (dir_q.key == idx_blk);
  assign del_n_final = del_n + FW'(del_hit);
  assign room      = DIR_SIZE - dir_fill;

  // walk counters, read addresses run one step ahead of the registered data
  always_comb begin
    if (cmd.clr_walk) begin
      slot_next = '0;
    end else if (cmd.del_step || cmd.com_step) begin
      slot_next = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    end else begin
      slot_next = slot;
    end
    if (cmd.clr_walk) begin
      lptr_next = '0;
    end else if (cmd.list_step || (cmd.com_step && slot_free)) begin
      lptr_next = lptr + 1'b1;
    end else begin
      lptr_next = lptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      lptr  <= '0;
      del_n <= '0;
    end else begin
      slot <= slot_next;
      lptr <= lptr_next;
      if (cmd.clr_walk) begin
        del_n <= '0;
      end else if (cmd.del_step) begin
        del_n <= del_n_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.com_step && slot_free) begin
      dir_mem[slot] <= '{key: idx_blk, blk: pend_q};
    end
    dir_q <= dir_mem[slot_next];
  end

  always_ff @(posedge clk) begin
    if (append) begin
      pend_mem[pend_cnt[LW-1:0]] <= in_blk;
    end
    pend_q <= pend_mem[lptr_next[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q <= item.index_block;
    end
  end

  // open create request
  always_ff @(posedge clk) begin
    if (rst || cmd.close) begin
      pend_cnt <= '0;
      pend_err <= ST_PENDING;
      dup      <= 1'b0;
      req_map  <= '0;
    end else if (cmd.load && (item.kind == KIND_CREATE)) begin
      if (blk_oor) begin
        if (pend_err == ST_PENDING) begin
          pend_err <= ST_RANGE;
        end
      end else if (list_full) begin
        if (pend_err == ST_PENDING) begin
          pend_err <= ST_FULL;
        end
      end else begin
        pend_cnt        <= pend_cnt + 1'b1;
        dup             <= dup | req_map[in_blk];
        req_map[in_blk] <= 1'b1;
      end
    end
  end

  always_comb begin
    free_map_next  = free_map;
    dir_valid_next = dir_valid;
    if (cmd.del_step && del_hit) begin
      free_map_next[dir_q.blk] = 1'b0;
      dir_valid_next[slot]     = 1'b0;
    end
    if (cmd.fin_del) begin
      free_map_next[idx_blk] = 1'b0;
    end
    if (cmd.com_step && slot_free) begin
      free_map_next[pend_q] = 1'b1;
      dir_valid_next[slot]  = 1'b1;
    end
    if (cmd.fin_com) begin
      free_map_next[idx_blk] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map  <= '0;
      dir_valid <= '0;
      dir_fill  <= '0;
    end else begin
      free_map  <= free_map_next;
      dir_valid <= dir_valid_next;
      if (cmd.fin_del) begin
        dir_fill <= dir_fill - del_n_final;
      end else if (cmd.fin_com) begin
        dir_fill <= dir_fill + FW'(pend_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status <= cmd.code;
      case (cmd.chg_sel)
        CHG_ZERO: result.blocks_changed <= '0;
        CHG_DEL:  result.blocks_changed <= 7'(del_n_final);
        CHG_CNT:  result.blocks_changed <= 7'(pend_cnt);
        default:  result.blocks_changed <= '0;
      endcase
    end
  end

  always_comb begin
    sts.in_oor     = ({1'b0, item.index_block} >= NB_LIMIT);
    sts.idx_oor    = ({1'b0, idx_q} >= NB_LIMIT);
    sts.idx_busy   = free_map[idx_blk];
    sts.blk_conf   = dup | req_map[idx_blk];
    sts.list_hit   = free_map[pend_q];
    sts.list_last  = ({1'b0, lptr} + 1'b1) >= {1'b0, pend_cnt};
    sts.room_short = RW'(room) < RW'(pend_cnt);
    sts.slot_free  = slot_free;
    sts.slot_last  = (slot == SLOT_LAST);
    sts.del_found  = (del_n_final != '0);
    sts.err        = pend_err;
  end

endmodule

// ----- rtl/core/indexed_block_allocator.sv -----
// top level of the indexed block allocator
// joins iba_ctrl and iba_datapath; uses iba_pkg
//
// usage
//   input: drive item and raise start; the item transfers at a rising edge with start
//   high and busy low. kind selects a create item (one data block of a request, last
//   marks its final item) or a delete of the file named by index_block.
//   output: every item gives exactly one result, shown on result for one cycle with
//   done high. the receiver cannot stall, so each result must be taken when shown.
// latency and throughput
//   create item that is not last, or delete with index out of range: result in the
//   cycle after the transfer, busy stays low, so one item per cycle.
//   delete: the directory is walked one entry per cycle while busy is high, result
//   in the cycle after the walk.
//   final create item: a check state, then a walk of the listed blocks while the
//   list is checked against the bitmap, then a walk of the directory filling the
//   lowest free directory slots.
// reset
//   synchronous; the free bitmap, the directory valid bits, the fill count and any
//   open create request are cleared at once, with no clearing pass.
module indexed_block_allocator
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64,
  parameter int DIR_DEPTH  = 64,
  parameter int MAX_LIST   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  iba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .last  (item.last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // bitmap, directory and pending list live here
  iba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .DIR_DEPTH  (DIR_DEPTH),
    .MAX_LIST   (MAX_LIST)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

endmodule

// ----- rtl/core/iba_checker.sv -----
// port level checks for the indexed block allocator
// bound to indexed_block_allocator; uses iba_pkg
module iba_checker
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  item,
  input logic done,
  input out_t result
);

  localparam logic [8:0] NB_LIMIT = 9'(NUM_BLOCKS);

  // a create item that is not last answers pending at once
  a_pending: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.kind == KIND_CREATE) && !item.last
    |=> done && (result.status == ST_PENDING))
    else $error("create item without last did not answer pending");

  // a delete of an out of range index answers range at once
  a_del_range: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.kind == KIND_DELETE) && ({1'b0, item.index_block} >= NB_LIMIT)
    |=> done && (result.status == ST_RANGE) && (result.blocks_changed == 7'd0))
    else $error("out of range delete did not answer range");

  // only allocated or deleted results carry a block count
  a_changed: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_ALLOC) && (result.status != ST_DELETED)
    |-> (result.blocks_changed == 7'd0))
    else $error("block count on a result that changed nothing");

  // leaving a long operation always delivers its result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

endmodule

bind indexed_block_allocator iba_checker #(
  .NUM_BLOCKS (NUM_BLOCKS)
) u_iba_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

// ----- bench/tb.sv -----
// self-checking bench for indexed_block_allocator: predicts status and block counts
// for creates and deletes and checks every result strobe against the prediction
// depends on iba_pkg and the allocator rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iba_pkg::*;

  localparam int NB = 64;
  localparam int DD = 64;
  localparam int ML = 16;
  localparam int BW = $clog2(NB);
  localparam int ITEM_TARGET = 1100;
  // no idling in the closing stretch of the run
  localparam int QUIET_FROM = 950;
  localparam int DRAIN_EVERY = 300;

  // allocation tracker: own copy of the bitmap, directory and open request,
  // plus the queue of results still owed by the block
  class block_alloc_tracker;
    logic [NB-1:0] block_used;
    logic [BW-1:0] entry_key [DD];
    logic [BW-1:0] entry_block [DD];
    bit            entry_valid [DD];
    int unsigned   entry_count;
    logic [BW-1:0] req_blocks [ML];
    int unsigned   req_len;
    status_t       req_err;
    out_t          awaited_results [$];
    int unsigned   mismatches;

    function new();
      block_used  = '0;
      entry_count = 0;
      req_len     = 0;
      req_err     = ST_PENDING;
      mismatches  = 0;
      foreach (entry_valid[i]) begin
        entry_valid[i] = 1'b0;
        entry_key[i]   = '0;
        entry_block[i] = '0;
      end
    endfunction

    // check order: first recorded error, index range, index taken,
    // listed block taken / equal to index / repeated, directory room
    function status_t run_commit(logic [7:0] idx, output int unsigned moved);
      int unsigned room;
      int unsigned j;
      moved = 0;
      room  = 0;
      j     = 0;
      if (req_err != ST_PENDING) return req_err;
      if (idx >= NB) return ST_RANGE;
      if (block_used[idx[BW-1:0]]) return ST_INDEX_BUSY;
      for (int i = 0; i < req_len; i++) begin
        if (block_used[req_blocks[i]] || req_blocks[i] == idx[BW-1:0]) return ST_BLOCK_BUSY;
        for (int k = 0; k < i; k++)
          if (req_blocks[k] == req_blocks[i]) return ST_BLOCK_BUSY;
      end
      for (int i = 0; i < DD; i++)
        if (!entry_valid[i]) room++;
      if (room < req_len) return ST_FULL;
      block_used[idx[BW-1:0]] = 1'b1;
      // lowest free slots first
      for (int i = 0; i < DD && j < req_len; i++) begin
        if (!entry_valid[i]) begin
          entry_valid[i] = 1'b1;
          entry_key[i]   = idx[BW-1:0];
          entry_block[i] = req_blocks[j];
          block_used[req_blocks[j]] = 1'b1;
          j++;
        end
      end
      entry_count += req_len;
      moved = req_len;
      return ST_ALLOC;
    endfunction

    function status_t run_delete(logic [7:0] idx, output int unsigned freed);
      freed = 0;
      if (idx >= NB) return ST_RANGE;
      for (int i = 0; i < DD; i++) begin
        if (entry_valid[i] && entry_key[i] == idx[BW-1:0]) begin
          block_used[entry_block[i]] = 1'b0;
          entry_valid[i] = 1'b0;
          freed++;
        end
      end
      if (freed == 0) return ST_NOT_FOUND;
      block_used[idx[BW-1:0]] = 1'b0;
      entry_count -= freed;
      return ST_DELETED;
    endfunction

    function void note_item(in_t it);
      out_t        r;
      status_t     st;
      int unsigned n;
      n = 0;
      if (it.kind == KIND_DELETE) begin
        st = run_delete(it.index_block, n);
      end else begin
        if (it.data_block >= NB) begin
          if (req_err == ST_PENDING) req_err = ST_RANGE;
        end else if (req_len >= ML) begin
          if (req_err == ST_PENDING) req_err = ST_FULL;
        end else begin
          req_blocks[req_len] = it.data_block[BW-1:0];
          req_len++;
        end
        if (it.last) begin
          st = run_commit(it.index_block, n);
          if (st != ST_ALLOC) n = 0;
          req_len = 0;
          req_err = ST_PENDING;
        end else begin
          st = ST_PENDING;
        end
      end
      r.status         = st;
      r.blocks_changed = 7'(n);
      awaited_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d changed %0d",
                 $time, got.status, got.blocks_changed);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.blocks_changed !== want.blocks_changed) begin
        $display("%0t: blocks_changed expected %0d actual %0d",
                 $time, want.blocks_changed, got.blocks_changed);
        mismatches++;
      end
    endfunction

    // a free block if there is one, else any in-range block
    function logic [7:0] free_block();
      int unsigned cand [$];
      for (int i = 0; i < NB; i++)
        if (!block_used[i]) cand.push_back(i);
      if (cand.size() == 0) return 8'($urandom_range(0, NB - 1));
      return 8'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // key of a live file if there is one, else any number at all
    function logic [7:0] live_key();
      int unsigned cand [$];
      for (int i = 0; i < DD; i++)
        if (entry_valid[i]) cand.push_back(entry_key[i]);
      if (cand.size() == 0) return 8'($urandom_range(0, 255));
      return 8'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    function int unsigned free_count();
      int unsigned c;
      c = 0;
      for (int i = 0; i < NB; i++)
        if (!block_used[i]) c++;
      return c;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  item;
  logic done;
  out_t result;

  block_alloc_tracker tracker;
  int unsigned items_sent;
  int unsigned gap_pct;

  indexed_block_allocator #(
    .NUM_BLOCKS(NB),
    .DIR_DEPTH (DD),
    .MAX_LIST  (ML)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: the receiver never stalls, every strobe is one transfer
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  function automatic in_t mk(logic kind, logic [7:0] idx, logic [7:0] blk, logic last);
    in_t it;
    it.kind        = kind;
    it.index_block = idx;
    it.data_block  = blk;
    it.last        = last;
    return it;
  endfunction

  // holds start high until the transfer, then maybe drops it for a random gap
  task automatic send_item(input in_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(it);
    items_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // sender holds off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_delete(input logic [7:0] idx);
    send_item(mk(KIND_DELETE, idx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  // one create request with random content, sometimes a delete slipped inside
  task automatic random_create();
    int unsigned len;
    int unsigned p;
    logic [7:0]  blk;
    logic [7:0]  idx;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, ML + 2) : $urandom_range(1, 4);
    for (int j = 0; j < len; j++) begin
      p = $urandom_range(0, 99);
      if (p < 80)      blk = tracker.free_block();
      else if (p < 96) blk = 8'($urandom_range(0, NB - 1));
      else             blk = 8'($urandom_range(NB, 255));
      if (j == len - 1) begin
        p = $urandom_range(0, 99);
        if (p < 85)      idx = tracker.free_block();
        else if (p < 95) idx = 8'($urandom_range(0, NB - 1));
        else             idx = 8'($urandom_range(NB, 255));
        send_item(mk(KIND_CREATE, idx, blk, 1'b1));
      end else begin
        // index field is ignored until the final item
        send_item(mk(KIND_CREATE, 8'($urandom_range(0, 255)), blk, 1'b0));
        if ($urandom_range(0, 19) == 0) send_delete(tracker.live_key());
      end
    end
  endtask

  initial begin
    int unsigned next_drain;
    int unsigned req_no;
    int unsigned del_pct;
    tracker    = new();
    items_sent = 0;
    gap_pct    = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: deletes on an empty directory and out of range
    send_item(mk(KIND_DELETE, 8'd0, 8'd0, 1'b0));
    send_item(mk(KIND_DELETE, 8'd255, 8'd255, 1'b1));
    send_item(mk(KIND_DELETE, 8'd64, 8'd0, 1'b0));
    // plain three-block file under index 0
    send_item(mk(KIND_CREATE, 8'd0, 8'd1, 1'b0));
    send_item(mk(KIND_CREATE, 8'd0, 8'd2, 1'b0));
    send_item(mk(KIND_CREATE, 8'd0, 8'd3, 1'b1));
    // data block equal to the index block, then the top block used properly
    send_item(mk(KIND_CREATE, 8'd63, 8'd63, 1'b1));
    send_item(mk(KIND_CREATE, 8'd62, 8'd63, 1'b1));
    // index already taken, data block already taken
    send_item(mk(KIND_CREATE, 8'd0, 8'd10, 1'b1));
    send_item(mk(KIND_CREATE, 8'd5, 8'd1, 1'b1));
    // data out of range early in the request, index out of range at the end
    send_item(mk(KIND_CREATE, 8'd0, 8'd255, 1'b0));
    send_item(mk(KIND_CREATE, 8'd8, 8'd7, 1'b1));
    send_item(mk(KIND_CREATE, 8'd200, 8'd9, 1'b1));
    send_item(mk(KIND_CREATE, 8'd255, 8'd0, 1'b1));
    // block repeated within one request
    send_item(mk(KIND_CREATE, 8'd0, 8'd11, 1'b0));
    send_item(mk(KIND_CREATE, 8'd12, 8'd11, 1'b1));
    // delete served while a create is open, then the create commits
    send_item(mk(KIND_CREATE, 8'd0, 8'd20, 1'b0));
    send_item(mk(KIND_DELETE, 8'd0, 8'd0, 1'b0));
    send_item(mk(KIND_CREATE, 8'd22, 8'd21, 1'b1));
    send_item(mk(KIND_DELETE, 8'd62, 8'd0, 1'b0));
    send_item(mk(KIND_DELETE, 8'd22, 8'd0, 1'b0));
    send_item(mk(KIND_DELETE, 8'd22, 8'd0, 1'b0));

    // random: mostly well-formed creates, deletes of live files, some noise
    next_drain = DRAIN_EVERY;
    req_no     = 0;
    while (items_sent < ITEM_TARGET) begin
      if (req_no % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (items_sent >= QUIET_FROM) gap_pct = 0;
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      // lean on deletes once the bitmap runs short
      del_pct = (tracker.free_count() < 12) ? 60 : 25;
      if ($urandom_range(0, 99) < del_pct) begin
        if ($urandom_range(0, 9) < 8) send_delete(tracker.live_key());
        else send_delete(8'($urandom_range(0, 255)));
      end else begin
        random_create();
      end
      req_no++;
    end

    // wind down: every owed result back, then the longest walk on top
    start <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (2 * DD + 40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, several times the slowest correct run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/iba_pkg.sv
rtl/core/iba_ctrl.sv
rtl/core/iba_datapath.sv
rtl/core/indexed_block_allocator.sv
rtl/core/iba_checker.sv
bench/tb.sv
